// ===== rtl/core/pwmbcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwmbcd_pkg
// Shared types, constants and helper functions of the pulse width meter
// with its multiplexed BCD seven-segment display.
// ----------------------------------------------------------------------------
package pwmbcd_pkg;

    localparam int WIDTH_W     = 8;
    localparam int PRESCALE_W  = 11;
    localparam int PCOUNT_W    = 10;
    localparam int SCAN_W      = 16;
    localparam int DIGIT_W     = 4;
    localparam int SELECT_W    = 4;
    localparam int SEG_W       = 7;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [PRESCALE_W-1:0] PRESCALE_MAX   = 11'd1024;
    localparam logic [PRESCALE_W-1:0] PRESCALE_MIN   = 11'd1;
    localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 11'd8;
    localparam logic [SCAN_W-1:0]     SCAN_RESET     = 16'd20000;

    // Leftmost digit is scanned first.
    localparam logic [SELECT_W-1:0] SELECT_FIRST = 4'b1000;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESCALE    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCAN_PERIOD = 1'b1;

    // Scan positions
    localparam logic [1:0] POS_THOUSANDS = 2'd0;
    localparam logic [1:0] POS_HUNDREDS  = 2'd1;
    localparam logic [1:0] POS_TENS      = 2'd2;
    localparam logic [1:0] POS_UNITS     = 2'd3;

    typedef struct packed {
        logic [DIGIT_W-1:0] hundreds;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] units;
    } bcd_t;

    // One queue entry: outcome of one accepted tick.
    typedef struct packed {
        logic               capture;
        logic [WIDTH_W-1:0] raw;
        bcd_t               digits;
    } tick_t;

    function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        begin
            case (d)
                4'd0:    s = 7'h3f;
                4'd1:    s = 7'h06;
                4'd2:    s = 7'h5b;
                4'd3:    s = 7'h4f;
                4'd4:    s = 7'h66;
                4'd5:    s = 7'h6d;
                4'd6:    s = 7'h7d;
                4'd7:    s = 7'h07;
                4'd8:    s = 7'h7f;
                4'd9:    s = 7'h6f;
                default: s = 7'h00;
            endcase
            return s;
        end
    endfunction

    // Split an 8-bit value into hundreds, tens and units.
    // Tens come from a multiply by 205/2048, exact for values below 100.
    function automatic bcd_t bcd_split(input logic [WIDTH_W-1:0] v);
        bcd_t          r;
        logic [6:0]    rem;
        logic [14:0]   prod;
        logic [3:0]    tens;
        logic [6:0]    tens_x10;
        begin
            if (v >= 8'd200)
            begin
                r.hundreds = 4'd2;
                rem        = 7'(v - 8'd200);
            end
            else if (v >= 8'd100)
            begin
                r.hundreds = 4'd1;
                rem        = 7'(v - 8'd100);
            end
            else
            begin
                r.hundreds = 4'd0;
                rem        = v[6:0];
            end
            prod     = 15'(rem) * 15'd205;
            tens     = prod[14:11];
            tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
            r.tens   = tens;
            r.units  = 4'(rem - tens_x10);
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pwmbcd_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwmbcd_in_if
// Input channel: one sampled pulse level per transaction.
// ----------------------------------------------------------------------------
interface pwmbcd_in_if;
    logic valid;
    logic ready;
    logic signal_level;

    modport source (output valid, output signal_level, input ready);
    modport sink   (input valid, input signal_level, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pwmbcd_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwmbcd_out_if
// Output channel: captured width and display drive per transaction.
// ----------------------------------------------------------------------------
interface pwmbcd_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [pwmbcd_pkg::WIDTH_W-1:0]       raw_width;
    logic [pwmbcd_pkg::SELECT_W-1:0]      digit_select;
    logic [pwmbcd_pkg::SEG_W-1:0]         segments;
    logic                                 capture_done;

    modport source (output valid, output raw_width, output digit_select,
                    output segments, output capture_done, input ready);
    modport sink   (input valid, input raw_width, input digit_select,
                    input segments, input capture_done, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pwmbcd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwmbcd_front
// Edge detection, prescaler and width counter; classifies each tick and
// pushes its outcome (capture flag, width, decimal digits) to the queue.
// ----------------------------------------------------------------------------
module pwmbcd_front (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    pwmbcd_in_if.sink                                  pulse_in,
    input  wire logic [pwmbcd_pkg::PRESCALE_W-1:0]     prescale,
    input  wire logic                                  q_full,
    output logic                                       q_push,
    output pwmbcd_pkg::tick_t                          q_entry
);

    logic                                prev_reg;
    logic                                prev_next;
    logic                                measuring_reg;
    logic                                measuring_next;
    logic [pwmbcd_pkg::PCOUNT_W-1:0]     pcount_reg;
    logic [pwmbcd_pkg::PCOUNT_W-1:0]     pcount_next;
    logic [pwmbcd_pkg::WIDTH_W-1:0]      width_reg;
    logic [pwmbcd_pkg::WIDTH_W-1:0]      width_next;

    logic                                rising;
    logic                                falling;
    logic [pwmbcd_pkg::PRESCALE_W-1:0]   eff_prescale;
    logic [pwmbcd_pkg::PRESCALE_W-1:0]   pcount_inc;
    logic                                accept;

    assign pulse_in.ready = !q_full;
    assign accept         = pulse_in.valid && pulse_in.ready;
    assign q_push         = accept;

    always_comb
    begin
        rising  = !prev_reg && pulse_in.signal_level;
        falling = prev_reg && !pulse_in.signal_level;

        if (prescale == '0)
            eff_prescale = pwmbcd_pkg::PRESCALE_MIN;
        else if (prescale > pwmbcd_pkg::PRESCALE_MAX)
            eff_prescale = pwmbcd_pkg::PRESCALE_MAX;
        else
            eff_prescale = prescale;

        pcount_inc = {1'b0, pcount_reg} + 11'd1;

        prev_next      = pulse_in.signal_level;
        measuring_next = measuring_reg;
        pcount_next    = pcount_reg;
        width_next     = width_reg;

        if (!measuring_reg)
        begin
            if (rising)
            begin
                measuring_next = 1'b1;
                pcount_next    = '0;
            end
        end
        else if (falling)
        begin
            width_next     = '0;
            measuring_next = 1'b0;
        end
        else if (pcount_inc >= eff_prescale)
        begin
            pcount_next = '0;
            width_next  = width_reg + 8'd1;
        end
        else
        begin
            pcount_next = pcount_inc[pwmbcd_pkg::PCOUNT_W-1:0];
        end

        q_entry.capture = measuring_reg && falling;
        q_entry.raw     = width_reg;
        q_entry.digits  = pwmbcd_pkg::bcd_split(width_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= 1'b0;
            measuring_reg <= 1'b0;
            pcount_reg    <= '0;
            width_reg     <= '0;
        end
        else if (accept)
        begin
            prev_reg      <= prev_next;
            measuring_reg <= measuring_next;
            pcount_reg    <= pcount_next;
            width_reg     <= width_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/pwmbcd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwmbcd_queue
// Two-entry queue between the measuring front and the display back.
// ----------------------------------------------------------------------------
module pwmbcd_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire pwmbcd_pkg::tick_t    push_entry,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      not_empty,
    output pwmbcd_pkg::tick_t         head
);

    pwmbcd_pkg::tick_t  entries [2];
    logic               wr_ptr_reg;
    logic               wr_ptr_next;
    logic               rd_ptr_reg;
    logic               rd_ptr_next;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic               do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entries[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = push   ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_entry;
    end

endmodule
`default_nettype wire

// ===== rtl/core/pwmbcd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwmbcd_back
// Display scanner: holds the decimal digits, steps the digit scan and
// drives the output register with the held width and display code.
// ----------------------------------------------------------------------------
module pwmbcd_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [pwmbcd_pkg::SCAN_W-1:0]     scan_period,
    input  wire logic                              q_not_empty,
    input  wire pwmbcd_pkg::tick_t                 q_head,
    output logic                                   q_pop,
    pwmbcd_out_if.source                           disp_out
);

    pwmbcd_pkg::bcd_t                    digits_reg;
    pwmbcd_pkg::bcd_t                    digits_next;
    logic [pwmbcd_pkg::SCAN_W-1:0]       scan_count_reg;
    logic [pwmbcd_pkg::SCAN_W-1:0]       scan_count_next;
    logic [1:0]                          scan_index_reg;
    logic [1:0]                          scan_index_next;
    logic [pwmbcd_pkg::WIDTH_W-1:0]      raw_reg;
    logic [pwmbcd_pkg::WIDTH_W-1:0]      raw_next;
    logic [pwmbcd_pkg::SELECT_W-1:0]     select_reg;
    logic [pwmbcd_pkg::SELECT_W-1:0]     select_next;
    logic [pwmbcd_pkg::SEG_W-1:0]        seg_reg;
    logic [pwmbcd_pkg::SEG_W-1:0]        seg_next;
    logic                                done_reg;
    logic                                valid_reg;
    logic                                valid_next;
    logic [pwmbcd_pkg::DIGIT_W-1:0]      scan_digit;

    // Advance only when the output register is free or being drained.
    assign q_pop = q_not_empty && (!valid_reg || disp_out.ready);

    assign disp_out.valid        = valid_reg;
    assign disp_out.raw_width    = raw_reg;
    assign disp_out.digit_select = select_reg;
    assign disp_out.segments     = seg_reg;
    assign disp_out.capture_done = done_reg;

    always_comb
    begin
        // A capture on this tick is visible to a scan on the same tick.
        digits_next = q_head.capture ? q_head.digits : digits_reg;
        raw_next    = q_head.capture ? q_head.raw : raw_reg;

        case (scan_index_reg)
            pwmbcd_pkg::POS_THOUSANDS: scan_digit = '0;
            pwmbcd_pkg::POS_HUNDREDS:  scan_digit = digits_next.hundreds;
            pwmbcd_pkg::POS_TENS:      scan_digit = digits_next.tens;
            pwmbcd_pkg::POS_UNITS:     scan_digit = digits_next.units;
            default:                   scan_digit = '0;
        endcase

        if (scan_count_reg >= scan_period)
        begin
            scan_count_next = '0;
            select_next     = pwmbcd_pkg::SELECT_FIRST >> scan_index_reg;
            seg_next        = pwmbcd_pkg::seg_code(scan_digit);
            scan_index_next = scan_index_reg + 2'd1;
        end
        else
        begin
            scan_count_next = scan_count_reg + 16'd1;
            select_next     = select_reg;
            seg_next        = seg_reg;
            scan_index_next = scan_index_reg;
        end

        if (q_pop)
            valid_next = 1'b1;
        else if (disp_out.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digits_reg     <= '0;
            scan_count_reg <= '0;
            scan_index_reg <= '0;
            raw_reg        <= '0;
            select_reg     <= '0;
            seg_reg        <= '0;
            done_reg       <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (q_pop)
            begin
                digits_reg     <= digits_next;
                scan_count_reg <= scan_count_next;
                scan_index_reg <= scan_index_next;
                raw_reg        <= raw_next;
                select_reg     <= select_next;
                seg_reg        <= seg_next;
                done_reg       <= q_head.capture;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/pulse_width_meter_bcd_display.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_width_meter_bcd_display
// Pulse width meter with a scanned four-digit seven-segment display.
// ----------------------------------------------------------------------------
// Each input transaction is one system tick carrying the sampled pulse level,
// and each produces exactly one output transaction with the last captured
// width, the current one-hot digit select and its segment code, and a flag
// set on the tick that captured a new width. The block takes one transaction
// per clock cycle while the queue is not full; each accepted transaction is
// written into the two-entry queue, then moves into the output register and
// shows up on the output. When the output side stalls, the queue absorbs two
// transactions before input ready drops. Write prescale (index 0) and
// scan_period (index 1) only while no transactions are in flight.
module pulse_width_meter_bcd_display (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    pwmbcd_in_if.sink                                   pulse_in,
    pwmbcd_out_if.source                                disp_out,
    input  wire logic                                   cfg_we,
    input  wire logic [pwmbcd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [pwmbcd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    logic [pwmbcd_pkg::PRESCALE_W-1:0]  prescale_reg;
    logic [pwmbcd_pkg::SCAN_W-1:0]      scan_period_reg;

    pwmbcd_pkg::tick_t                  push_entry;
    pwmbcd_pkg::tick_t                  head_entry;
    logic                               q_push;
    logic                               q_full;
    logic                               q_pop;
    logic                               q_not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg    <= pwmbcd_pkg::PRESCALE_RESET;
            scan_period_reg <= pwmbcd_pkg::SCAN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pwmbcd_pkg::CFG_PRESCALE:
                    prescale_reg <= cfg_wdata[pwmbcd_pkg::PRESCALE_W-1:0];
                pwmbcd_pkg::CFG_SCAN_PERIOD:
                    scan_period_reg <= cfg_wdata[pwmbcd_pkg::SCAN_W-1:0];
                default:
                    ;
            endcase
        end
    end

    pwmbcd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pulse_in (pulse_in),
        .prescale (prescale_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    pwmbcd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (head_entry)
    );

    pwmbcd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .scan_period (scan_period_reg),
        .q_not_empty (q_not_empty),
        .q_head      (head_entry),
        .q_pop       (q_pop),
        .disp_out    (disp_out)
    );

endmodule
`default_nettype wire

// ===== sim/pulse_width_meter_bcd_display_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_width_meter_bcd_display_test
// Self-checking bench for the pulse width meter and its scanned display.
// A short table of hand-picked ticks exercises reset values, edge ticks,
// prescale clamping, fast scanning and period changes. Randomized phases of
// pulse trains follow, each under new register settings. Every display
// transaction is compared with a hand-written word or a cycle-level model of the meter.
// ----------------------------------------------------------------------------
module pulse_width_meter_bcd_display_test;

    localparam int RANDOM_ITEMS = 1525;
    localparam int CALM_ITEMS   = 200;
    localparam int SETTLE_TICKS = 4;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum logic [0:0] {ROW_LEVEL, ROW_CONFIG} row_kind_t;

    typedef struct packed {
        logic [pwmbcd_pkg::WIDTH_W-1:0]  raw_width;
        logic [pwmbcd_pkg::SELECT_W-1:0] digit_select;
        logic [pwmbcd_pkg::SEG_W-1:0]    segments;
        logic                            capture_done;
    } disp_word_t;

    typedef struct packed {
        row_kind_t                          kind;
        logic [pwmbcd_pkg::CFG_INDEX_W-1:0] reg_index;
        logic [pwmbcd_pkg::CFG_DATA_W-1:0]  value;
        logic [7:0]                         reps;
        logic                               literal;
        disp_word_t                         lit;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [pwmbcd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [pwmbcd_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    pwmbcd_in_if  pulse_in ();
    pwmbcd_out_if disp_out ();

    pulse_width_meter_bcd_display DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pulse_in  (pulse_in),
        .disp_out  (disp_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Meter model state
    logic [pwmbcd_pkg::PRESCALE_W-1:0] cur_prescale;
    logic [pwmbcd_pkg::SCAN_W-1:0]     cur_scan_period;
    logic                              lvl_prev;
    logic                              measuring;
    int unsigned                       pre_count;
    logic [pwmbcd_pkg::WIDTH_W-1:0]    width_count;
    logic [pwmbcd_pkg::DIGIT_W-1:0]    digits [4];
    int unsigned                       scan_count;
    logic [1:0]                        scan_pos;
    logic [pwmbcd_pkg::WIDTH_W-1:0]    shown_raw;
    logic [pwmbcd_pkg::SELECT_W-1:0]   shown_select;
    logic [pwmbcd_pkg::SEG_W-1:0]      shown_segments;

    disp_word_t expected_display [$];
    stim_row_t  plan [$];

    int  mismatches = 0;
    int  cycles = 0;
    int  ticks_sent = 0;
    int  random_sent = 0;
    int  captures = 0;
    int  reg_writes = 0;
    int  widest = 0;
    bit  calm = 1'b0;
    bit  steady = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_display.size());
            $display("** pulse_width_meter_bcd_display: FAILED **");
            $finish;
        end
    end

    function automatic logic [pwmbcd_pkg::SEG_W-1:0] digit_glyph(
        input logic [pwmbcd_pkg::DIGIT_W-1:0] d);
        logic [pwmbcd_pkg::SEG_W-1:0] g;
        case (d)
            4'd0:    g = 7'h3f;
            4'd1:    g = 7'h06;
            4'd2:    g = 7'h5b;
            4'd3:    g = 7'h4f;
            4'd4:    g = 7'h66;
            4'd5:    g = 7'h6d;
            4'd6:    g = 7'h7d;
            4'd7:    g = 7'h07;
            4'd8:    g = 7'h7f;
            4'd9:    g = 7'h6f;
            default: g = 7'h00;
        endcase
        return g;
    endfunction

    // Advance the meter by one tick and return the display word it drives.
    function automatic disp_word_t meter_tick(input logic lvl);
        disp_word_t  w;
        int unsigned step;
        logic        rise;
        logic        fall;
        rise = !lvl_prev && lvl;
        fall = lvl_prev && !lvl;
        step = (cur_prescale == 0) ? 1 : ((cur_prescale > 1024) ? 1024 : cur_prescale);
        w.capture_done = 1'b0;
        if (!measuring)
        begin
            if (rise)
            begin
                measuring = 1'b1;
                pre_count = 0;
            end
        end
        else if (fall)
        begin
            shown_raw   = width_count;
            digits[0]   = 4'd0;
            digits[1]   = 4'(width_count / 100);
            digits[2]   = 4'((width_count / 10) % 10);
            digits[3]   = 4'(width_count % 10);
            width_count = '0;
            measuring   = 1'b0;
            w.capture_done = 1'b1;
        end
        else
        begin
            pre_count = pre_count + 1;
            if (pre_count >= step)
            begin
                pre_count   = 0;
                width_count = width_count + 1'b1;
            end
        end
        lvl_prev = lvl;

        // Display runs after capture, so a scan on a capture tick shows new digits.
        if (scan_count >= cur_scan_period)
        begin
            scan_count     = 0;
            shown_select   = pwmbcd_pkg::SELECT_FIRST >> scan_pos;
            shown_segments = digit_glyph(digits[scan_pos]);
            scan_pos       = scan_pos + 1'b1;
        end
        else
        begin
            scan_count = (scan_count + 1) & 32'hffff;
        end

        w.raw_width    = shown_raw;
        w.digit_select = shown_select;
        w.segments     = shown_segments;
        return w;
    endfunction

    function automatic stim_row_t mk_row(input row_kind_t kind,
                                         input logic [pwmbcd_pkg::CFG_INDEX_W-1:0] idx,
                                         input logic [pwmbcd_pkg::CFG_DATA_W-1:0] value,
                                         input int reps,
                                         input logic literal,
                                         input disp_word_t lit);
        stim_row_t r;
        r.kind      = kind;
        r.reg_index = idx;
        r.value     = value;
        r.reps      = 8'(reps);
        r.literal   = literal;
        r.lit       = lit;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_level(input logic lvl, input logic literal, input disp_word_t lit);
        disp_word_t w;
        pulse_in.valid        <= 1'b1;
        pulse_in.signal_level <= lvl;
        @(posedge clk);
        while (!pulse_in.ready)
        begin
            @(negedge clk);
            @(posedge clk);
        end
        w = meter_tick(lvl);
        expected_display.push_back(literal ? lit : w);
        ticks_sent = ticks_sent + 1;
        if (w.capture_done)
        begin
            captures = captures + 1;
            if (int'(w.raw_width) > widest)
                widest = int'(w.raw_width);
        end
        @(negedge clk);
    endtask

    task automatic feed(input logic lvl);
        // Drop anything past the random budget.
        if (random_sent >= RANDOM_ITEMS)
            return;
        if (!calm && !steady && $urandom_range(0, 4) == 0)
        begin
            pulse_in.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        send_level(lvl, 1'b0, '0);
        random_sent = random_sent + 1;
        if (random_sent >= RANDOM_ITEMS - CALM_ITEMS)
            calm = 1'b1;
    endtask

    // Hold off input until every transaction in flight has drained.
    task automatic settle();
        pulse_in.valid <= 1'b0;
        while (expected_display.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic write_reg(input logic [pwmbcd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [pwmbcd_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        if (idx == pwmbcd_pkg::CFG_PRESCALE)
            cur_prescale = data[pwmbcd_pkg::PRESCALE_W-1:0];
        else
            cur_scan_period = data;
        reg_writes = reg_writes + 1;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Output side: random stall bursts, none in the closing stretch.
    initial
    begin : sink_side
        int stall;
        stall = 0;
        disp_out.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                disp_out.ready <= 1'b0;
                stall = stall - 1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                disp_out.ready <= 1'b0;
                stall = $urandom_range(1, 6) - 1;
            end
            else
            begin
                disp_out.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && disp_out.valid && disp_out.ready)
        begin
            if (expected_display.size() == 0)
            begin
                $display("%0t: display transaction with nothing expected", $time);
                mismatches = mismatches + 1;
            end
            else
            begin : compare
                disp_word_t e;
                e = expected_display.pop_front();
                if (disp_out.raw_width !== e.raw_width)
                begin
                    $display("%0t: raw_width expected %0d, got %0d",
                             $time, e.raw_width, disp_out.raw_width);
                    mismatches = mismatches + 1;
                end
                if (disp_out.digit_select !== e.digit_select)
                begin
                    $display("%0t: digit_select expected %b, got %b",
                             $time, e.digit_select, disp_out.digit_select);
                    mismatches = mismatches + 1;
                end
                if (disp_out.segments !== e.segments)
                begin
                    $display("%0t: segments expected %h, got %h",
                             $time, e.segments, disp_out.segments);
                    mismatches = mismatches + 1;
                end
                if (disp_out.capture_done !== e.capture_done)
                begin
                    $display("%0t: capture_done expected %b, got %b",
                             $time, e.capture_done, disp_out.capture_done);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [pwmbcd_pkg::PRESCALE_W-1:0] new_prescale;
        logic [pwmbcd_pkg::SCAN_W-1:0]     new_scan;
        int                                pick;
        int                                which;
        int                                phase_end;
        int                                run;

        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_wdata             = '0;
        pulse_in.valid        = 1'b0;
        pulse_in.signal_level = 1'b0;

        cur_prescale    = pwmbcd_pkg::PRESCALE_RESET;
        cur_scan_period = pwmbcd_pkg::SCAN_RESET;
        lvl_prev        = 1'b0;
        measuring       = 1'b0;
        pre_count       = 0;
        width_count     = '0;
        digits          = '{default: '0};
        scan_count      = 0;
        scan_pos        = '0;
        shown_raw       = '0;
        shown_select    = '0;
        shown_segments  = '0;

        // Reset settings: quick start/stop gives width 0, nine high ticks give width 1.
        plan.push_back(mk_row(ROW_LEVEL, '0, 16'd1, 1, 1'b1, '0));
        plan.push_back(mk_row(ROW_LEVEL, '0, 16'd0, 1, 1'b1,
                              disp_word_t'({8'd0, 4'd0, 7'd0, 1'b1})));
        plan.push_back(mk_row(ROW_LEVEL, '0, 16'd1, 9, 1'b0, '0));
        plan.push_back(mk_row(ROW_LEVEL, '0, 16'd0, 1, 1'b1,
                              disp_word_t'({8'd1, 4'd0, 7'd0, 1'b1})));
        // Scan every tick; prescale of zero counts as one.
        plan.push_back(mk_row(ROW_CONFIG, pwmbcd_pkg::CFG_SCAN_PERIOD, 16'd0, 0, 1'b0, '0));
        plan.push_back(mk_row(ROW_CONFIG, pwmbcd_pkg::CFG_PRESCALE, 16'd0, 0, 1'b0, '0));
        plan.push_back(mk_row(ROW_LEVEL, '0, 16'd1, 3, 1'b0, '0));
        plan.push_back(mk_row(ROW_LEVEL, '0, 16'd0, 1, 1'b0, '0));
        plan.push_back(mk_row(ROW_LEVEL, '0, 16'd0, 3, 1'b0, '0));
        // Oversized prescale saturates.
        plan.push_back(mk_row(ROW_CONFIG, pwmbcd_pkg::CFG_PRESCALE, 16'h07ff, 0, 1'b0, '0));
        plan.push_back(mk_row(ROW_LEVEL, '0, 16'd1, 2, 1'b0, '0));
        plan.push_back(mk_row(ROW_LEVEL, '0, 16'd0, 1, 1'b0, '0));
        // Upper data bits beyond the prescale field are dropped.
        plan.push_back(mk_row(ROW_CONFIG, pwmbcd_pkg::CFG_PRESCALE, 16'hf801, 0, 1'b0, '0));
        plan.push_back(mk_row(ROW_CONFIG, pwmbcd_pkg::CFG_SCAN_PERIOD, 16'hffff, 0, 1'b0, '0));
        plan.push_back(mk_row(ROW_LEVEL, '0, 16'd1, 2, 1'b0, '0));
        plan.push_back(mk_row(ROW_LEVEL, '0, 16'd0, 1, 1'b0, '0));
        // Period dropped under the running count: advance on the next tick.
        plan.push_back(mk_row(ROW_CONFIG, pwmbcd_pkg::CFG_SCAN_PERIOD, 16'd2, 0, 1'b0, '0));
        plan.push_back(mk_row(ROW_LEVEL, '0, 16'd0, 1, 1'b0, '0));

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CONFIG)
            begin
                settle();
                write_reg(plan[i].reg_index, plan[i].value);
            end
            else
            begin
                for (int r = 0; r < int'(plan[i].reps); r++)
                    send_level(plan[i].value[0], plan[i].literal, plan[i].lit);
            end
        end

        while (random_sent < RANDOM_ITEMS)
        begin
            settle();

            pick = $urandom_range(0, 99);
            if (pick < 40)
                new_prescale = pwmbcd_pkg::PRESCALE_W'($urandom_range(1, 3));
            else if (pick < 60)
                new_prescale = pwmbcd_pkg::PRESCALE_W'($urandom_range(4, 16));
            else if (pick < 70)
                new_prescale = '0;
            else if (pick < 80)
                new_prescale = pwmbcd_pkg::PRESCALE_MAX;
            else if (pick < 90)
                new_prescale = pwmbcd_pkg::PRESCALE_W'($urandom_range(1025, 2047));
            else
                new_prescale = pwmbcd_pkg::PRESCALE_W'($urandom_range(1, 1024));

            pick = $urandom_range(0, 99);
            if (pick < 30)
                new_scan = '0;
            else if (pick < 70)
                new_scan = pwmbcd_pkg::SCAN_W'($urandom_range(1, 8));
            else if (pick < 85)
                new_scan = pwmbcd_pkg::SCAN_W'($urandom_range(9, 300));
            else if (pick < 95)
                new_scan = 16'hffff;
            else
                new_scan = pwmbcd_pkg::SCAN_W'($urandom);

            which = $urandom_range(0, 9);
            if (which < 4)
            begin
                write_reg(pwmbcd_pkg::CFG_PRESCALE, {5'($urandom), new_prescale});
                write_reg(pwmbcd_pkg::CFG_SCAN_PERIOD, new_scan);
            end
            else if (which < 8)
            begin
                write_reg(pwmbcd_pkg::CFG_SCAN_PERIOD, new_scan);
                write_reg(pwmbcd_pkg::CFG_PRESCALE, {5'($urandom), new_prescale});
            end
            else if (which == 8)
                write_reg(pwmbcd_pkg::CFG_PRESCALE, {5'($urandom), new_prescale});
            else
                write_reg(pwmbcd_pkg::CFG_SCAN_PERIOD, new_scan);

            steady    = ($urandom_range(0, 9) < 3);
            phase_end = random_sent + $urandom_range(60, 200);
            while (random_sent < phase_end && random_sent < RANDOM_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    // Glitchy level: random bits, including one-tick pulses.
                    repeat ($urandom_range(1, 10)) feed(1'($urandom));
                end
                else
                begin
                    repeat ($urandom_range(1, 8)) feed(1'b0);
                    if (pick < 70)
                        run = $urandom_range(1, 30);
                    else if (pick < 88)
                        run = $urandom_range(31, 120);
                    else
                        run = $urandom_range(200, 600);
                    repeat (run) feed(1'b1);
                end
            end
        end

        settle();
        repeat (10) @(negedge clk);

        $display("Sent %0d ticks over %0d register writes; %0d widths captured, widest %0d.",
                 ticks_sent, reg_writes, captures, widest);
        $display("Prescale swept from zero through saturation, scan period from 0 to 65535.");
        if (mismatches == 0)
            $display("** pulse_width_meter_bcd_display: PASSED **");
        else
            $display("** pulse_width_meter_bcd_display: FAILED **");
        $finish;
    end

endmodule
